[src/nearest_neighbor_warp_gather_assert.svh]
// Assertion macros shared by the warp gather modules.
// NNWG_ASSERT_IMP checks cons in the same cycle as ante.
// NNWG_ASSERT_NXT checks cons in the cycle after ante.
`ifndef NEAREST_NEIGHBOR_WARP_GATHER_ASSERT_SVH
`define NEAREST_NEIGHBOR_WARP_GATHER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define NNWG_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nnwg assertion failed");
`define NNWG_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nnwg assertion failed");
`else
`define NNWG_ASSERT_IMP(label, clk, rst, ante, cons)
`define NNWG_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

[src/nnwg_pkg.sv]
package nnwg_pkg;

   // item and result fields
   localparam int COORD_W   = 16;
   localparam int INDEX_W   = 16;
   localparam int PIX_W     = 8;
   localparam int COORD_FRAC = 14;

   // image store
   localparam int ADDR_W      = 16;
   localparam int IMAGE_DEPTH = 1 << ADDR_W;

   // extents and index arithmetic
   localparam int EXT_W      = 9;
   localparam int MAX_EXTENT = 256;
   localparam int POS_W      = 8;
   localparam int T_W        = COORD_FRAC + 2;
   localparam int PROD_W     = T_W + POS_W;
   localparam int ROW_W      = POS_W + EXT_W;
   localparam int IDX_W      = ROW_W + EXT_W;

   localparam logic signed [COORD_W-1:0] COORD_ONE     = COORD_W'(1 << COORD_FRAC);
   localparam logic signed [COORD_W-1:0] COORD_NEG_ONE = -COORD_ONE;

   // front pipeline depth and queue sizing
   localparam int PIPE_STAGES = 4;
   localparam int Q_DEPTH     = 8;
   localparam int Q_PTR_W     = $clog2(Q_DEPTH);
   localparam int Q_CNT_W     = Q_PTR_W + 1;

   // command codes
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_WARP  = 1'b1;

   // configuration register map
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [1:0] REG_SIZE_X = 2'd0;
   localparam logic [1:0] REG_SIZE_Y = 2'd1;
   localparam logic [1:0] REG_SIZE_Z = 2'd2;
   localparam logic [EXT_W-1:0] SIZE_X_RESET = EXT_W'(64);
   localparam logic [EXT_W-1:0] SIZE_Y_RESET = EXT_W'(64);
   localparam logic [EXT_W-1:0] SIZE_Z_RESET = EXT_W'(16);

   typedef struct packed {
      logic               command;
      logic [INDEX_W-1:0] write_index;
      logic [PIX_W-1:0]   write_pixel;
      logic [COORD_W-1:0] coord_x;
      logic [COORD_W-1:0] coord_y;
      logic [COORD_W-1:0] coord_z;
   } item_type;

   // effective extents, each in 1..MAX_EXTENT
   typedef struct packed {
      logic [EXT_W-1:0] x;
      logic [EXT_W-1:0] y;
      logic [EXT_W-1:0] z;
   } extent_type;

   // one beat handed from the front to the back
   typedef struct packed {
      logic              command;
      logic              out_of_range;
      logic [ADDR_W-1:0] addr;
      logic [PIX_W-1:0]  pixel;
   } beat_type;

   typedef struct packed {
      logic empty;
      logic near_full;
   } qstat_type;

endpackage

[src/nearest_neighbor_warp_gather.sv]
// Path: a warp beat passes four index stages, one queue slot and one registered store read
//   before it shows on rsp_*.
// Throughput: one beat per cycle, write or warp; busy stays low while the back end drains.
// Reset: synchronous, active high; clears pipeline valids, queue pointers and the size
//   registers (64, 64, 16). The image store is not cleared; read only written entries.
// The receiver cannot stall: each result is driven for exactly one cycle under rsp_strobe.
module nearest_neighbor_warp_gather (
   input  logic                              clock,
   input  logic                              reset,

   // command channel
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_command,
   input  logic [nnwg_pkg::INDEX_W-1:0]      req_write_index,
   input  logic [nnwg_pkg::PIX_W-1:0]        req_write_pixel,
   input  logic signed [nnwg_pkg::COORD_W-1:0] req_coord_x,
   input  logic signed [nnwg_pkg::COORD_W-1:0] req_coord_y,
   input  logic signed [nnwg_pkg::COORD_W-1:0] req_coord_z,

   // result channel
   output logic                              rsp_strobe,
   output logic [nnwg_pkg::PIX_W-1:0]        rsp_pixel,
   output logic                              rsp_out_of_range,

   // configuration port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [nnwg_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [nnwg_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [nnwg_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);
   import nnwg_pkg::*;

   // ------------------------------------------------------------------
   // Configuration registers: size_x, size_y, size_z at 0x0, 0x4, 0x8.
   // ------------------------------------------------------------------
   logic [EXT_W-1:0] size_x_ff, size_x_in;
   logic [EXT_W-1:0] size_y_ff, size_y_in;
   logic [EXT_W-1:0] size_z_ff, size_z_in;
   logic             csr_write;
   logic [1:0]       csr_index;
   logic [EXT_W-1:0] csr_rd_value;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[3:2];

   always_comb begin
      size_x_in = size_x_ff;
      size_y_in = size_y_ff;
      size_z_in = size_z_ff;
      if (csr_write) begin
         case (csr_index)
            REG_SIZE_X: begin
               size_x_in = pwdata[EXT_W-1:0];
            end
            REG_SIZE_Y: begin
               size_y_in = pwdata[EXT_W-1:0];
            end
            REG_SIZE_Z: begin
               size_z_in = pwdata[EXT_W-1:0];
            end
            default: begin
               // unmapped offset: drop the write
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= SIZE_X_RESET;
         size_y_ff <= SIZE_Y_RESET;
         size_z_ff <= SIZE_Z_RESET;
      end else begin
         size_x_ff <= size_x_in;
         size_y_ff <= size_y_in;
         size_z_ff <= size_z_in;
      end
   end

   always_comb begin
      case (csr_index)
         REG_SIZE_X: csr_rd_value = size_x_ff;
         REG_SIZE_Y: csr_rd_value = size_y_ff;
         REG_SIZE_Z: csr_rd_value = size_z_ff;
         default:    csr_rd_value = '0;
      endcase
   end

   assign prdata = CSR_DATA_W'(csr_rd_value);

   // ------------------------------------------------------------------
   // Effective extents: a zero size acts as one, anything above the
   // largest extent saturates. Sizes must only change while idle; the
   // block does not enforce this, and the front pipeline reads them live.
   // ------------------------------------------------------------------
   function automatic logic [EXT_W-1:0] eff_extent(input logic [EXT_W-1:0] s);
      if (s == '0) begin
         return EXT_W'(1);
      end else if (s > EXT_W'(MAX_EXTENT)) begin
         return EXT_W'(MAX_EXTENT);
      end
      return s;
   endfunction

   extent_type ext;

   assign ext.x = eff_extent(size_x_ff);
   assign ext.y = eff_extent(size_y_ff);
   assign ext.z = eff_extent(size_z_ff);

   // ------------------------------------------------------------------
   // Front: accept a beat, clamp and scale the coordinates, build the
   // linear index. Writes ride the same pipeline so store order holds.
   // ------------------------------------------------------------------
   item_type  item;
   logic      accept;
   logic      front_push;
   beat_type  front_beat;
   beat_type  queue_head;
   qstat_type queue_stat;
   logic      back_pop;

   assign item.command     = req_command;
   assign item.write_index = req_write_index;
   assign item.write_pixel = req_write_pixel;
   assign item.coord_x     = req_coord_x;
   assign item.coord_y     = req_coord_y;
   assign item.coord_z     = req_coord_z;

   // hold off new beats only when the queue could not absorb the pipeline
   assign busy   = queue_stat.near_full;
   assign accept = start && !busy;

   nnwg_front u_front (
      .clock (clock),
      .reset (reset),
      .accept(accept),
      .item  (item),
      .ext   (ext),
      .push  (front_push),
      .beat  (front_beat)
   );

   // ------------------------------------------------------------------
   // Queue between front and back.
   // ------------------------------------------------------------------
   nnwg_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (front_push),
      .push_beat(front_beat),
      .pop      (back_pop),
      .head     (queue_head),
      .stat     (queue_stat)
   );

   // ------------------------------------------------------------------
   // Back: drain one beat per cycle into the image store; a warp beat
   // reads the store and produces one result.
   // ------------------------------------------------------------------
   assign back_pop = !queue_stat.empty;

   nnwg_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pop             (back_pop),
      .beat            (queue_head),
      .rsp_strobe      (rsp_strobe),
      .rsp_pixel       (rsp_pixel),
      .rsp_out_of_range(rsp_out_of_range)
   );

endmodule

[src/nnwg_front.sv]
module nnwg_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  nnwg_pkg::item_type  item,
   input  nnwg_pkg::extent_type ext,
   output logic                push,
   output nnwg_pkg::beat_type  beat
);
   import nnwg_pkg::*;

   // clamp to [-1, 1] and shift into [0, 2]
   function automatic logic [T_W-1:0] shift_coord(input logic [COORD_W-1:0] raw);
      logic signed [COORD_W-1:0] c;
      logic signed [COORD_W:0]   s;
      c = $signed(raw);
      if (c > COORD_ONE) begin
         c = COORD_ONE;
      end else if (c < COORD_NEG_ONE) begin
         c = COORD_NEG_ONE;
      end
      s = {c[COORD_W-1], c} + {COORD_ONE[COORD_W-1], COORD_ONE};
      return s[T_W-1:0];
   endfunction

   // round half up: (prod + ONE) >> (frac + 1)
   function automatic logic [POS_W-1:0] round_pos(input logic [PROD_W-1:0] prod);
      logic [PROD_W:0] s;
      s = {1'b0, prod} + (PROD_W+1)'(COORD_ONE);
      return s[COORD_FRAC+1 +: POS_W];
   endfunction

   // stage A: captured item
   logic     va_ff;
   item_type a_ff;

   // stage B: scaled coordinates
   logic               vb_ff;
   logic               b_cmd_ff;
   logic [INDEX_W-1:0] b_widx_ff;
   logic [PIX_W-1:0]   b_wpix_ff;
   logic [PROD_W-1:0]  b_px_ff, b_py_ff, b_pz_ff;
   logic [PROD_W-1:0]  b_px_in, b_py_in, b_pz_in;

   // stage C: row term
   logic               vc_ff;
   logic               c_cmd_ff;
   logic [INDEX_W-1:0] c_widx_ff;
   logic [PIX_W-1:0]   c_wpix_ff;
   logic [ROW_W-1:0]   c_row_ff, c_row_in;
   logic [POS_W-1:0]   c_pz_ff, c_pz_in;

   // stage D: linear index
   logic               vd_ff;
   logic               d_cmd_ff;
   logic [INDEX_W-1:0] d_widx_ff;
   logic [PIX_W-1:0]   d_wpix_ff;
   logic [IDX_W-1:0]   d_idx_ff, d_idx_in;

   logic [POS_W-1:0] span_x, span_y, span_z;

   always_comb begin
      span_x  = POS_W'(ext.x - EXT_W'(1));
      span_y  = POS_W'(ext.y - EXT_W'(1));
      span_z  = POS_W'(ext.z - EXT_W'(1));
      b_px_in = {{POS_W{1'b0}}, shift_coord(a_ff.coord_x)} * {{T_W{1'b0}}, span_x};
      b_py_in = {{POS_W{1'b0}}, shift_coord(a_ff.coord_y)} * {{T_W{1'b0}}, span_y};
      b_pz_in = {{POS_W{1'b0}}, shift_coord(a_ff.coord_z)} * {{T_W{1'b0}}, span_z};
      c_row_in = {{EXT_W{1'b0}}, round_pos(b_px_ff)} * {{POS_W{1'b0}}, ext.y}
                 + {{EXT_W{1'b0}}, round_pos(b_py_ff)};
      c_pz_in  = round_pos(b_pz_ff);
      d_idx_in = {{EXT_W{1'b0}}, c_row_ff} * {{ROW_W{1'b0}}, ext.z}
                 + {{(IDX_W - POS_W){1'b0}}, c_pz_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else begin
         va_ff <= accept;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_ff      <= item;
      b_cmd_ff  <= a_ff.command;
      b_widx_ff <= a_ff.write_index;
      b_wpix_ff <= a_ff.write_pixel;
      b_px_ff   <= b_px_in;
      b_py_ff   <= b_py_in;
      b_pz_ff   <= b_pz_in;
      c_cmd_ff  <= b_cmd_ff;
      c_widx_ff <= b_widx_ff;
      c_wpix_ff <= b_wpix_ff;
      c_row_ff  <= c_row_in;
      c_pz_ff   <= c_pz_in;
      d_cmd_ff  <= c_cmd_ff;
      d_widx_ff <= c_widx_ff;
      d_wpix_ff <= c_wpix_ff;
      d_idx_ff  <= d_idx_in;
   end

   assign push = vd_ff;

   always_comb begin
      beat.command      = d_cmd_ff;
      beat.pixel        = d_wpix_ff;
      beat.out_of_range = 1'b0;
      beat.addr         = ADDR_W'(d_widx_ff);
      if (d_cmd_ff == CMD_WARP) begin
         beat.out_of_range = (d_idx_ff >= IDX_W'(IMAGE_DEPTH));
         beat.addr         = d_idx_ff[ADDR_W-1:0];
      end
   end

endmodule

[src/nnwg_queue.sv]
module nnwg_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  nnwg_pkg::beat_type  push_beat,
   input  logic                pop,
   output nnwg_pkg::beat_type  head,
   output nnwg_pkg::qstat_type stat
);
   import nnwg_pkg::*;
   `include "nearest_neighbor_warp_gather_assert.svh"

   beat_type            slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]  wr_ff, wr_in;
   logic [Q_PTR_W-1:0]  rd_ff, rd_in;
   logic [Q_CNT_W-1:0]  cnt_ff, cnt_in;

   always_comb begin
      wr_in  = push ? wr_ff + Q_PTR_W'(1) : wr_ff;
      rd_in  = pop  ? rd_ff + Q_PTR_W'(1) : rd_ff;
      cnt_in = cnt_ff + Q_CNT_W'(push) - Q_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_beat;
      end
   end

   assign head           = slot_ff[rd_ff];
   assign stat.empty     = (cnt_ff == '0);
   // leave room for every beat still in the front pipeline
   assign stat.near_full = (cnt_ff > Q_CNT_W'(Q_DEPTH - PIPE_STAGES));

   `NNWG_ASSERT_IMP(a_no_pop_empty, clock, reset, pop, cnt_ff != '0)
   `NNWG_ASSERT_IMP(a_no_overflow, clock, reset, push && !pop, cnt_ff < Q_CNT_W'(Q_DEPTH))

endmodule

[src/nnwg_back.sv]
module nnwg_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      pop,
   input  nnwg_pkg::beat_type        beat,
   output logic                      rsp_strobe,
   output logic [nnwg_pkg::PIX_W-1:0] rsp_pixel,
   output logic                      rsp_out_of_range
);
   import nnwg_pkg::*;
   `include "nearest_neighbor_warp_gather_assert.svh"

   logic [PIX_W-1:0] image_ff [IMAGE_DEPTH];
   logic [PIX_W-1:0] rd_pix_ff;
   logic             strobe_ff, strobe_in;
   logic             oor_ff;
   logic             is_warp;

   assign is_warp   = (beat.command == CMD_WARP);
   assign strobe_in = pop && is_warp;

   always_ff @(posedge clock) begin
      if (pop && !is_warp) begin
         image_ff[beat.addr] <= beat.pixel;
      end
      rd_pix_ff <= image_ff[beat.addr];
      oor_ff    <= beat.out_of_range;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_out_of_range = oor_ff;
   // drop the stored pixel for a lookup outside the store
   assign rsp_pixel        = oor_ff ? '0 : rd_pix_ff;

   `NNWG_ASSERT_NXT(a_warp_gives_beat, clock, reset, pop && is_warp, rsp_strobe)
   `NNWG_ASSERT_NXT(a_write_silent, clock, reset, !(pop && is_warp), !rsp_strobe)

endmodule
